// ----- src/bgf_pkg.sv -----
// ----------------------------------------------------------------------------
// bgf_pkg
// Shared constants, register map and helpers for the gradient fill pipeline.
// ----------------------------------------------------------------------------
package bgf_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    localparam int PIX_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int GRAD_W  = 10;
    localparam int COLOR_W = 24;
    localparam int CH_W    = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // coordinate bits actually used
    localparam int X_W = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;

    // divider: restoring, DIV_STEPS quotient bits per stage
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int REM_W      = SIZE_W;

    // position / factor, Q1.FRAC_BITS, range 0..1 inclusive
    localparam int T_W       = FRAC_BITS + 1;
    localparam int GRAD_FRAC = 8;
    localparam int GMAG_W    = GRAD_FRAC + 1;
    localparam int GRAD_MAX  = 256;
    localparam int SUB_W     = FRAC_BITS + GRAD_FRAC + 1;
    localparam int FXY_W     = 2 * T_W;
    localparam int PROD_W    = FXY_W + CH_W;

    localparam logic [T_W-1:0]   FRAC_ONE = T_W'(1) << FRAC_BITS;
    localparam logic [SUB_W-1:0] SUB_ONE  = SUB_W'(1) << (FRAC_BITS + GRAD_FRAC);
    localparam logic [CH_W-1:0]  ALPHA_VAL = 8'hFF;

    // pipeline: divider stages, product, factor, factor product, channel
    localparam int PIPE_DEPTH = DIV_STAGES + 4;

    typedef enum logic [2:0] {
        REG_BASE_COLOR  = 3'd0,
        REG_FILL_WIDTH  = 3'd1,
        REG_FILL_HEIGHT = 3'd2,
        REG_GRAD_X      = 3'd3,
        REG_GRAD_Y      = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic              neg;
        logic [GMAG_W-1:0] mag;
    } grad_t;

    // clamp strength to -1..1 and split into sign and magnitude
    function automatic grad_t sat_grad(input logic signed [GRAD_W-1:0] g);
        grad_t                    r;
        logic signed [GRAD_W-1:0] a;
        r.neg = (g < 0);
        if (g > GRAD_MAX)
            a = GRAD_W'(GRAD_MAX);
        else if (g < -GRAD_MAX)
            a = GRAD_W'(GRAD_MAX);
        else if (r.neg)
            a = -g;
        else
            a = g;
        r.mag = a[GMAG_W-1:0];
        return r;
    endfunction

endpackage

// ----- src/bilinear_gradient_fill_pixel.sv -----
// ----------------------------------------------------------------------------
// bilinear_gradient_fill_pixel
// Gradient-shaded rectangle fill, one RGBA pixel per coordinate item.
// ----------------------------------------------------------------------------
// Pipeline: 12 register stages; done marks each result leaving the last one.
// Throughput: one item per clock; busy is never raised, done never waits.
// Depth is set by the 8-stage position divider (2 quotient bits per stage)
// followed by four multiply and subtract stages.
// Reset: rst_n clears the in-flight valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module bilinear_gradient_fill_pixel
    import bgf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // item in
    input  logic              start,
    output logic              busy,
    input  logic [PIX_W-1:0]  pix_x,
    input  logic [PIX_W-1:0]  pix_y,
    // item out
    output logic              done,
    output logic [CH_W-1:0]   red,
    output logic [CH_W-1:0]   green,
    output logic [CH_W-1:0]   blue,
    output logic [CH_W-1:0]   alpha,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0]       base_color_reg;
    logic [SIZE_W-1:0]        fill_width_reg;
    logic [SIZE_W-1:0]        fill_height_reg;
    logic signed [GRAD_W-1:0] grad_x_reg;
    logic signed [GRAD_W-1:0] grad_y_reg;

    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_color_reg  <= '1;
            fill_width_reg  <= SIZE_W'(1);
            fill_height_reg <= SIZE_W'(1);
            grad_x_reg      <= '0;
            grad_y_reg      <= '0;
        end
        else if (wr_en)
        begin
            // addresses past the last register are dropped
            unique case (reg_idx)
                REG_BASE_COLOR:  base_color_reg  <= pwdata[COLOR_W-1:0];
                REG_FILL_WIDTH:  fill_width_reg  <= pwdata[SIZE_W-1:0];
                REG_FILL_HEIGHT: fill_height_reg <= pwdata[SIZE_W-1:0];
                REG_GRAD_X:      grad_x_reg      <= pwdata[GRAD_W-1:0];
                REG_GRAD_Y:      grad_y_reg      <= pwdata[GRAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BASE_COLOR:  prdata = DATA_W'(base_color_reg);
            REG_FILL_WIDTH:  prdata = DATA_W'(fill_width_reg);
            REG_FILL_HEIGHT: prdata = DATA_W'(fill_height_reg);
            REG_GRAD_X:      prdata = DATA_W'(unsigned'(grad_x_reg));
            REG_GRAD_Y:      prdata = DATA_W'(unsigned'(grad_y_reg));
            default:         prdata = '0;
        endcase
    end

    // The user must change registers only while idle; the block does not enforce
    // it. The pipeline reads them directly. A size of zero behaves as one.
    logic [SIZE_W-1:0] width_eff;
    logic [SIZE_W-1:0] height_eff;
    grad_t             gx;
    grad_t             gy;

    assign width_eff  = (fill_width_reg  == '0) ? SIZE_W'(1) : fill_width_reg;
    assign height_eff = (fill_height_reg == '0) ? SIZE_W'(1) : fill_height_reg;
    assign gx         = sat_grad(grad_x_reg);
    assign gy         = sat_grad(grad_y_reg);

    // ------------------------------------------------------------------
    // Valid chain: never stalls, so an item is taken on every start
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;

    assign busy     = 1'b0;
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // ------------------------------------------------------------------
    // Stages 1..8: position t = x / size in Q1.16, saturating at 1.0
    // ------------------------------------------------------------------
    logic [T_W-1:0] tx;
    logic [T_W-1:0] ty;

    bgf_div u_div_x
    (
        .clk (clk),
        .num (pix_x[X_W-1:0]),
        .den (width_eff),
        .t   (tx)
    );

    bgf_div u_div_y
    (
        .clk (clk),
        .num (pix_y[X_W-1:0]),
        .den (height_eff),
        .t   (ty)
    );

    // ------------------------------------------------------------------
    // Stage 9: strength times distance. A negative strength darkens from
    // the near edge, so it works on 1 - t.
    // ------------------------------------------------------------------
    logic [T_W-1:0]   mx;
    logic [T_W-1:0]   my;
    logic [SUB_W-1:0] sub_x_next;
    logic [SUB_W-1:0] sub_y_next;
    logic [SUB_W-1:0] sub_x_reg;
    logic [SUB_W-1:0] sub_y_reg;

    assign mx         = gx.neg ? T_W'(FRAC_ONE - tx) : tx;
    assign my         = gy.neg ? T_W'(FRAC_ONE - ty) : ty;
    assign sub_x_next = SUB_W'(gx.mag) * SUB_W'(mx);
    assign sub_y_next = SUB_W'(gy.mag) * SUB_W'(my);

    // ------------------------------------------------------------------
    // Stage 10: factor = (1.0 - sub) in Q1.16, product never exceeds 1.0
    // ------------------------------------------------------------------
    logic [SUB_W-1:0] diff_x;
    logic [SUB_W-1:0] diff_y;
    logic [T_W-1:0]   fx_reg;
    logic [T_W-1:0]   fy_reg;

    assign diff_x = SUB_ONE - sub_x_reg;
    assign diff_y = SUB_ONE - sub_y_reg;

    // ------------------------------------------------------------------
    // Stage 11: combined factor fx * fy, Q2.32
    // ------------------------------------------------------------------
    logic [FXY_W-1:0] fxy_next;
    logic [FXY_W-1:0] fxy_reg;

    assign fxy_next = FXY_W'(fx_reg) * FXY_W'(fy_reg);

    // ------------------------------------------------------------------
    // Stage 12: scale each channel, keep the integer part
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] prod_r;
    logic [PROD_W-1:0] prod_g;
    logic [PROD_W-1:0] prod_b;
    logic [CH_W-1:0]   red_reg;
    logic [CH_W-1:0]   green_reg;
    logic [CH_W-1:0]   blue_reg;

    assign prod_r = PROD_W'(base_color_reg[23:16]) * PROD_W'(fxy_reg);
    assign prod_g = PROD_W'(base_color_reg[15:8])  * PROD_W'(fxy_reg);
    assign prod_b = PROD_W'(base_color_reg[7:0])   * PROD_W'(fxy_reg);

    // datapath registers carry no reset; valid bits qualify them
    always_ff @(posedge clk)
    begin
        sub_x_reg <= sub_x_next;
        sub_y_reg <= sub_y_next;
        fx_reg    <= diff_x[SUB_W-1:GRAD_FRAC];
        fy_reg    <= diff_y[SUB_W-1:GRAD_FRAC];
        fxy_reg   <= fxy_next;
        red_reg   <= prod_r[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];
        green_reg <= prod_g[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];
        blue_reg  <= prod_b[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];
    end

    assign done  = vld_reg[PIPE_DEPTH-1];
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;
    assign alpha = ALPHA_VAL;

endmodule

// ----- src/bgf_div.sv -----
// ----------------------------------------------------------------------------
// bgf_div
// Pipelined restoring divider: t = min(num * 2^FRAC_BITS / den, 1.0).
// ----------------------------------------------------------------------------
module bgf_div
    import bgf_pkg::*;
(
    input  logic              clk,
    input  logic [X_W-1:0]    num,
    input  logic [SIZE_W-1:0] den,   // never zero
    output logic [T_W-1:0]    t
);

    logic [REM_W-1:0]     rem_in   [DIV_STAGES];
    logic [FRAC_BITS-1:0] q_in     [DIV_STAGES];
    logic                 sat_in   [DIV_STAGES];
    logic [REM_W-1:0]     rem_next [DIV_STAGES];
    logic [FRAC_BITS-1:0] q_next   [DIV_STAGES];
    logic [REM_W-1:0]     rem_reg  [DIV_STAGES];
    logic [FRAC_BITS-1:0] q_reg    [DIV_STAGES];
    logic                 sat_reg  [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            if (k == 0) begin : g_first
                // num >= den means position at or past the edge: saturate
                assign rem_in[k] = REM_W'(num);
                assign q_in[k]   = '0;
                assign sat_in[k] = (REM_W'(num) >= den);
            end
            else begin : g_rest
                assign rem_in[k] = rem_reg[k-1];
                assign q_in[k]   = q_reg[k-1];
                assign sat_in[k] = sat_reg[k-1];
            end

            always_comb
            begin
                logic [REM_W-1:0]     r;
                logic [FRAC_BITS-1:0] q;
                logic [REM_W:0]       r2;
                r  = rem_in[k];
                q  = q_in[k];
                r2 = '0;
                for (int j = 0; j < DIV_STEPS; j++)
                begin
                    if (k * DIV_STEPS + j < FRAC_BITS)
                    begin
                        r2 = {r, 1'b0};
                        if (r2 >= {1'b0, den})
                        begin
                            r = REM_W'(r2 - {1'b0, den});
                            q = {q[FRAC_BITS-2:0], 1'b1};
                        end
                        else
                        begin
                            r = r2[REM_W-1:0];
                            q = {q[FRAC_BITS-2:0], 1'b0};
                        end
                    end
                end
                rem_next[k] = r;
                q_next[k]   = q;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                sat_reg[k] <= sat_in[k];
            end
        end
    endgenerate

    assign t = sat_reg[DIV_STAGES-1] ? FRAC_ONE : {1'b0, q_reg[DIV_STAGES-1]};

endmodule

// ----- verif/tb_top.sv -----
// ============================================================================
// tb_top
// Self-checking bench for the gradient fill pixel pipeline.
// A directed table of pixels walks the register extremes and edge cases. Then
// about 1700 random pixels follow under changing fill settings. Every accepted
// item is queued with its typed-in pixel or one shaded by a local model. Each
// done strobe is checked against the oldest queued pixel, channel by channel.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;
    import bgf_pkg::*;

    // watchdog, far above the slowest legal run
    localparam int LIMIT_CYCLES = 400000;

    localparam longint unsigned UNIT   = 64'd1 << FRAC_BITS;
    localparam longint unsigned UNIT_G = UNIT << GRAD_FRAC;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] a;
    } pixel_t;

    // one directed row: fill settings, coordinate, optional typed-in result
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
        logic [GRAD_W-1:0]  gx;
        logic [GRAD_W-1:0]  gy;
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic               typed;
        pixel_t             px;
    } fill_row_t;

    localparam pixel_t WHITE = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    localparam pixel_t BLACK = '{8'h00, 8'h00, 8'h00, 8'hFF};
    localparam pixel_t NONE  = '{8'h00, 8'h00, 8'h00, 8'h00};

    localparam int N_ROWS = 18;
    localparam fill_row_t FILL_ROWS [0:N_ROWS-1] = '{
        // reset defaults: no shading at all
        '{24'hFFFFFF, 13'd1,    13'd1,    10'h000, 10'h000, 12'd0,    12'd0,    1'b1, WHITE},
        // far past the edge with zero strength is still full colour
        '{24'hFFFFFF, 13'd1,    13'd1,    10'h000, 10'h000, 12'd4095, 12'd4095, 1'b1, WHITE},
        // black fill
        '{24'h000000, 13'd4096, 13'd4096, 10'h000, 10'h000, 12'd4095, 12'd0,    1'b1, BLACK},
        // full positive strength: bright at the left edge
        '{24'hFFFFFF, 13'd4096, 13'd4096, 10'h100, 10'h000, 12'd0,    12'd0,    1'b1, WHITE},
        '{24'hFFFFFF, 13'd4096, 13'd4096, 10'h100, 10'h000, 12'd4095, 12'd0,    1'b0, NONE},
        // full negative strength: dark at the left edge
        '{24'hFFFFFF, 13'd4096, 13'd4096, 10'h300, 10'h000, 12'd0,    12'd0,    1'b1, BLACK},
        '{24'hFFFFFF, 13'd4096, 13'd4096, 10'h300, 10'h000, 12'd4095, 12'd0,    1'b0, NONE},
        // strength above range clamps to +1
        '{24'hFFFFFF, 13'd4096, 13'd4096, 10'h1FF, 10'h000, 12'd0,    12'd0,    1'b1, WHITE},
        // strength below range clamps to -1
        '{24'hFFFFFF, 13'd4096, 13'd4096, 10'h200, 10'h000, 12'd0,    12'd0,    1'b1, BLACK},
        // zero size behaves as one pixel
        '{24'hFFFFFF, 13'd0,    13'd0,    10'h100, 10'h000, 12'd0,    12'd0,    1'b1, WHITE},
        '{24'hFFFFFF, 13'd0,    13'd0,    10'h100, 10'h000, 12'd1,    12'd0,    1'b1, BLACK},
        // largest size register value
        '{24'hFFFFFF, 13'd8191, 13'd8191, 10'h100, 10'h100, 12'd4095, 12'd4095, 1'b0, NONE},
        // mid strengths, mixed signs
        '{24'h123456, 13'd100,  13'd50,   10'h080, 10'h380, 12'd50,   12'd25,   1'b0, NONE},
        // past the edge saturates the position
        '{24'h123456, 13'd100,  13'd50,   10'h080, 10'h380, 12'd200,  12'd49,   1'b0, NONE},
        // both gradients at +1, single pixel
        '{24'hFFFFFF, 13'd1,    13'd1,    10'h100, 10'h100, 12'd0,    12'd0,    1'b1, WHITE},
        // smallest non-zero strengths, then full strengths on mixed sizes
        '{24'h80FF01, 13'd256,  13'd256,  10'h3FF, 10'h001, 12'd255,  12'd255,  1'b0, NONE},
        '{24'hFF0000, 13'd2,    13'd2,    10'h300, 10'h300, 12'd1,    12'd1,    1'b0, NONE},
        '{24'h00FF00, 13'd4096, 13'd1,    10'h100, 10'h300, 12'd2048, 12'd0,    1'b0, NONE}
    };

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    logic [PIX_W-1:0]  pix_x   = '0;
    logic [PIX_W-1:0]  pix_y   = '0;
    logic              done;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [CH_W-1:0]   alpha;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // shadow copy of the fill registers, reset values
    logic [COLOR_W-1:0]       fill_color  = 24'hFFFFFF;
    logic [SIZE_W-1:0]        fill_w      = 13'd1;
    logic [SIZE_W-1:0]        fill_h      = 13'd1;
    logic signed [GRAD_W-1:0] fill_gx     = '0;
    logic signed [GRAD_W-1:0] fill_gy     = '0;

    pixel_t pending_pixels [$];
    int     errors = 0;

    bilinear_gradient_fill_pixel DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .pix_x   (pix_x),
        .pix_y   (pix_y),
        .done    (done),
        .red     (red),
        .green   (green),
        .blue    (blue),
        .alpha   (alpha),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shading model
    // ------------------------------------------------------------------------

    // one gradient factor, Q1.16 in 0..1
    function automatic longint unsigned grad_factor(input logic [PIX_W-1:0] pos,
                                                    input logic [SIZE_W-1:0] size,
                                                    input logic signed [GRAD_W-1:0] g);
        longint unsigned pos_q;
        longint unsigned sz;
        longint unsigned cut;
        longint unsigned mag;
        int              gs;
        sz    = (size == 0) ? 64'd1 : 64'(size);
        pos_q = (64'(pos) << FRAC_BITS) / sz;
        if (pos_q > UNIT)
            pos_q = UNIT;
        gs = g;
        if (gs > GRAD_MAX)
            gs = GRAD_MAX;
        if (gs < -GRAD_MAX)
            gs = -GRAD_MAX;
        // positive strength darkens towards the far edge, negative the near one
        if (gs >= 0)
        begin
            mag = 64'(gs);
            cut = mag * pos_q;
        end
        else
        begin
            mag = 64'(-gs);
            cut = mag * (UNIT - pos_q);
        end
        if (cut > UNIT_G)
            cut = UNIT_G;
        return (UNIT_G - cut) >> GRAD_FRAC;
    endfunction

    function automatic logic [CH_W-1:0] shade_channel(input logic [CH_W-1:0] c,
                                                      input longint unsigned fxy);
        longint unsigned prod;
        prod = 64'(c) * fxy;
        return CH_W'(prod >> (2 * FRAC_BITS));
    endfunction

    function automatic pixel_t shade_pixel(input logic [PIX_W-1:0] x,
                                           input logic [PIX_W-1:0] y);
        longint unsigned fxy;
        pixel_t          px;
        fxy  = grad_factor(x, fill_w, fill_gx) * grad_factor(y, fill_h, fill_gy);
        px.r = shade_channel(fill_color[23:16], fxy);
        px.g = shade_channel(fill_color[15:8], fxy);
        px.b = shade_channel(fill_color[7:0], fxy);
        px.a = 8'hFF;
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // one APB write; shadow updated on the access edge
    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_BASE_COLOR:  fill_color = val[COLOR_W-1:0];
            REG_FILL_WIDTH:  fill_w     = val[SIZE_W-1:0];
            REG_FILL_HEIGHT: fill_h     = val[SIZE_W-1:0];
            REG_GRAD_X:      fill_gx    = val[GRAD_W-1:0];
            REG_GRAD_Y:      fill_gy    = val[GRAD_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // stop feeding and wait for every queued pixel to come back
    task automatic drain_pixels();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
    endtask

    // junk in the unused upper bits must be ignored
    function automatic logic [DATA_W-1:0] with_junk(input logic [DATA_W-1:0] val,
                                                    input int bits);
        logic [DATA_W-1:0] mask;
        mask = (DATA_W'(1) << bits) - 1;
        return ($urandom() & ~mask) | (val & mask);
    endfunction

    // registers only change with the pipe empty
    task automatic program_fill(input logic [COLOR_W-1:0] color,
                                input logic [SIZE_W-1:0] w,
                                input logic [SIZE_W-1:0] h,
                                input logic [GRAD_W-1:0] gx,
                                input logic [GRAD_W-1:0] gy);
        drain_pixels();
        repeat (PIPE_DEPTH + 2) @(posedge clk);
        apb_write(REG_BASE_COLOR, with_junk(DATA_W'(color), COLOR_W));
        apb_write(REG_FILL_WIDTH, with_junk(DATA_W'(w), SIZE_W));
        apb_write(REG_FILL_HEIGHT, with_junk(DATA_W'(h), SIZE_W));
        apb_write(REG_GRAD_X, with_junk(DATA_W'(gx), GRAD_W));
        apb_write(REG_GRAD_Y, with_junk(DATA_W'(gy), GRAD_W));
    endtask

    // present one item, optionally after a random gap; queue its pixel on accept
    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                              input int idle_pct, input logic typed, input pixel_t typed_px);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        pix_x <= x;
        pix_y <= y;
        do
            @(posedge clk);
        while (busy);
        pending_pixels.push_back(typed ? typed_px : shade_pixel(x, y));
    endtask

    // ------------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------------

    function automatic logic [COLOR_W-1:0] pick_color();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return 24'h000000;
        else if (sel < 10)
            return 24'hFFFFFF;
        return COLOR_W'($urandom());
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int sel;
        sel = $urandom_range(99);
        if (sel < 4)
            return 13'd0;
        else if (sel < 8)
            return 13'd1;
        else if (sel < 12)
            return 13'd4096;
        else if (sel < 15)
            return 13'd8191;
        else if (sel < 55)
            return SIZE_W'($urandom_range(64, 1));
        else if (sel < 90)
            return SIZE_W'($urandom_range(4096, 1));
        return SIZE_W'($urandom());
    endfunction

    function automatic logic [GRAD_W-1:0] pick_grad();
        int sel;
        int g;
        sel = $urandom_range(99);
        case (sel % 8)
            0: g = 0;
            1: g = GRAD_MAX;
            2: g = -GRAD_MAX;
            3: g = 511;
            4: g = -512;
            5: g = 1;
            default: g = -1;
        endcase
        if (sel >= 25)
            g = $urandom_range(2 * GRAD_MAX, 0) - GRAD_MAX;
        if (sel >= 90)
            g = $urandom();
        return GRAD_W'(g);
    endfunction

    // mostly inside the rectangle, some on the far edge, some anywhere
    function automatic logic [PIX_W-1:0] pick_coord(input logic [SIZE_W-1:0] size);
        int lim;
        int sel;
        if (size == 0)
            lim = 0;
        else if (size > 4096)
            lim = 4095;
        else
            lim = size - 1;
        sel = $urandom_range(99);
        if (sel < 80)
            return PIX_W'($urandom_range(lim, 0));
        else if (sel < 88)
            return PIX_W'(lim);
        return PIX_W'($urandom());
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every done strobe pops the oldest queued pixel
    // ------------------------------------------------------------------------

    task automatic check_channel(input string name, input logic [CH_W-1:0] want,
                                 input logic [CH_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected item %h %h %h %h",
                         $time, red, green, blue, alpha);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_channel("red", want.r, red);
                check_channel("green", want.g, green);
                check_channel("blue", want.b, blue);
                check_channel("alpha", want.a, alpha);
            end
        end
    end

    // watchdog
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        fill_row_t     row;
        int            idle_rates [3];
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;

        idle_rates = '{11, 84, 0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; registers only rewritten when a row changes them
        for (int i = 0; i < N_ROWS; i++)
        begin
            row = FILL_ROWS[i];
            if (row.color != fill_color || row.w != fill_w || row.h != fill_h ||
                row.gx != fill_gx || row.gy != fill_gy)
                program_fill(row.color, row.w, row.h, row.gx, row.gy);
            send_pixel(row.x, row.y, 0, row.typed, row.px);
        end

        // random: three idle regimes, fresh fill settings every segment
        for (int ph = 0; ph < 3; ph++)
        begin
            for (int seg = 0; seg < 10; seg++)
            begin
                w = pick_size();
                h = pick_size();
                program_fill(pick_color(), w, h, pick_grad(), pick_grad());
                for (int n = 0; n < 57; n++)
                begin
                    // sender holds off once per regime until the pipe runs dry
                    if (seg == 2 && n == 28)
                        drain_pixels();
                    send_pixel(pick_coord(w), pick_coord(h), idle_rates[ph], 1'b0, NONE);
                end
            end
        end

        drain_pixels();
        repeat (PIPE_DEPTH + 8) @(posedge clk);

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/bgf_pkg.sv
src/bgf_div.sv
src/bilinear_gradient_fill_pixel.sv
verif/tb_top.sv
